@@ hw/rtl/pfe_pkg.sv @@
// Playfair stream encryptor: shared types, constants and square lookups.
// No dependencies; imported by pfe_pair and playfair_stream_encrypt.
`default_nettype none

package pfe_pkg;

  typedef logic [4:0] letter_t;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } pos_t;

  localparam logic [7:0] UPPER_FIRST = 8'd65;
  localparam logic [7:0] UPPER_LAST  = 8'd90;
  localparam logic [7:0] LOWER_FIRST = 8'd97;
  localparam logic [7:0] LOWER_LAST  = 8'd122;
  localparam logic [7:0] CASE_OFFSET = 8'd32;
  localparam logic [6:0] ASCII_BASE  = 7'd97;

  localparam letter_t LETTER_I   = 5'd8;
  localparam letter_t LETTER_J   = 5'd9;
  localparam letter_t PAD_LETTER = 5'd23;

  localparam logic [2:0] LAST_INDEX = 3'd4;

  // Square by rows: e s m p i / o l a y f / r b c d g / h k n q t / u v w x z
  localparam letter_t SQUARE [25] = '{
    5'd4,  5'd18, 5'd12, 5'd15, 5'd8,
    5'd14, 5'd11, 5'd0,  5'd24, 5'd5,
    5'd17, 5'd1,  5'd2,  5'd3,  5'd6,
    5'd7,  5'd10, 5'd13, 5'd16, 5'd19,
    5'd20, 5'd21, 5'd22, 5'd23, 5'd25
  };

  function automatic pos_t letter_pos(letter_t l);
    pos_t p;
    case (l)
      5'd0:    p = '{3'd1, 3'd2};
      5'd1:    p = '{3'd2, 3'd1};
      5'd2:    p = '{3'd2, 3'd2};
      5'd3:    p = '{3'd2, 3'd3};
      5'd4:    p = '{3'd0, 3'd0};
      5'd5:    p = '{3'd1, 3'd4};
      5'd6:    p = '{3'd2, 3'd4};
      5'd7:    p = '{3'd3, 3'd0};
      5'd8:    p = '{3'd0, 3'd4};
      5'd9:    p = '{3'd0, 3'd4};
      5'd10:   p = '{3'd3, 3'd1};
      5'd11:   p = '{3'd1, 3'd1};
      5'd12:   p = '{3'd0, 3'd2};
      5'd13:   p = '{3'd3, 3'd2};
      5'd14:   p = '{3'd1, 3'd0};
      5'd15:   p = '{3'd0, 3'd3};
      5'd16:   p = '{3'd3, 3'd3};
      5'd17:   p = '{3'd2, 3'd0};
      5'd18:   p = '{3'd0, 3'd1};
      5'd19:   p = '{3'd3, 3'd4};
      5'd20:   p = '{3'd4, 3'd0};
      5'd21:   p = '{3'd4, 3'd1};
      5'd22:   p = '{3'd4, 3'd2};
      5'd23:   p = '{3'd4, 3'd3};
      5'd24:   p = '{3'd1, 3'd3};
      5'd25:   p = '{3'd4, 3'd4};
      default: p = '{3'd0, 3'd0};
    endcase
    return p;
  endfunction

  function automatic letter_t square_at(logic [2:0] row, logic [2:0] col);
    logic [4:0] idx;
    idx = {row[2:0], 2'b00} + {2'b00, row} + {2'b00, col};
    return SQUARE[idx];
  endfunction

  function automatic logic [2:0] wrap_inc(logic [2:0] v);
    return (v == LAST_INDEX) ? 3'd0 : v + 3'd1;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pfe_in_if.sv @@
// Playfair stream encryptor: input channel, one message byte per word.
// Depends on nothing.
`default_nettype none

interface pfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_message;

  modport source (output valid, output in_byte, output end_of_message, input ready);
  modport sink   (input valid, input in_byte, input end_of_message, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/pfe_out_if.sv @@
// Playfair stream encryptor: output channel, one cipher letter per word.
// Depends on nothing.
`default_nettype none

interface pfe_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] cipher_char;
  logic       last_of_run;

  modport source (output valid, output cipher_char, output last_of_run, input ready);
  modport sink   (input valid, input cipher_char, input last_of_run, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/pfe_pair.sv @@
// Playfair stream encryptor: combinational digraph encryption over the square.
// Depends on pfe_pkg.
`default_nettype none

module pfe_pair
  import pfe_pkg::*;
(
  input  letter_t first_i,
  input  letter_t second_i,
  output letter_t first_o,
  output letter_t second_o
);

  pos_t p1;
  pos_t p2;

  always_comb begin
    p1 = letter_pos(first_i);
    p2 = letter_pos(second_i);
    if (p1.row == p2.row) begin
      first_o  = square_at(p1.row, wrap_inc(p1.col));
      second_o = square_at(p2.row, wrap_inc(p2.col));
    end else if (p1.col == p2.col) begin
      first_o  = square_at(wrap_inc(p1.row), p1.col);
      second_o = square_at(wrap_inc(p2.row), p2.col);
    end else begin
      first_o  = square_at(p1.row, p2.col);
      second_o = square_at(p2.row, p1.col);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/playfair_stream_encrypt.sv @@
// Playfair stream encryptor top level: input register, pairing logic, result buffer.
// Depends on pfe_pkg, pfe_in_if, pfe_out_if and pfe_pair.
//
//   channel  dir  word contents
//   in_i     in   in_byte[7:0], end_of_message
//   out_o    out  cipher_char[6:0], last_of_run
//
// A byte is registered, then paired and encrypted combinationally into a
// four-letter result buffer; results leave one per cycle while out_o.ready is high.
// Bytes giving no result pass at one per cycle while the buffer is free; a pair
// fills two entries, and a doubled letter at end of message fills all four.
// Reset clears the pending letter and all valid flags.
// Output stalls back up through the buffer to in_i.ready.
`default_nettype none

module playfair_stream_encrypt
  import pfe_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  pfe_in_if.sink     in_i,
  pfe_out_if.source  out_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       eom_q;

  letter_t    held_q, held_d;
  logic       held_valid_q, held_valid_d;

  letter_t    res_q [4];
  letter_t    res_d [4];
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] idx_q;

  logic       out_last;
  logic       out_fire;
  logic       buf_free;
  logic       move;

  logic [7:0] folded;
  logic       is_letter;
  letter_t    cur;
  logic       first_pair;
  logic       doubled;
  letter_t    a_second;
  letter_t    a0, a1, b0, b1;
  letter_t    flush_letter;
  logic       flush_pair;

  assign out_o.valid       = (cnt_q != 3'd0);
  assign out_last          = ({1'b0, idx_q} == (cnt_q - 3'd1));
  assign out_o.cipher_char = ASCII_BASE + {2'b00, res_q[idx_q]};
  assign out_o.last_of_run = out_last;
  assign out_fire          = out_o.valid && out_o.ready;
  assign buf_free          = (cnt_q == 3'd0) || (out_fire && out_last);
  assign move              = in_valid_q && buf_free;
  assign in_i.ready        = !in_valid_q || buf_free;

  always_comb begin
    folded = in_byte_q;
    if (in_byte_q >= UPPER_FIRST && in_byte_q <= UPPER_LAST) begin
      folded = in_byte_q + CASE_OFFSET;
    end
    is_letter = (folded >= LOWER_FIRST) && (folded <= LOWER_LAST);
    cur       = 5'(folded - LOWER_FIRST);
    if (cur == LETTER_J) begin
      cur = LETTER_I;
    end
    first_pair = is_letter && held_valid_q;
    doubled    = (cur == held_q);
    a_second   = doubled ? PAD_LETTER : cur;

    held_d       = held_q;
    held_valid_d = held_valid_q;
    if (is_letter) begin
      if (held_valid_q) begin
        if (doubled) begin
          held_d       = cur;
          held_valid_d = 1'b1;
        end else begin
          held_valid_d = 1'b0;
        end
      end else begin
        held_d       = cur;
        held_valid_d = 1'b1;
      end
    end
    flush_letter = held_d;
    flush_pair   = eom_q && held_valid_d;
    if (flush_pair) begin
      held_valid_d = 1'b0;
    end

    res_d = res_q;
    cnt_d = 3'd0;
    if (first_pair) begin
      res_d[0] = a0;
      res_d[1] = a1;
      res_d[2] = b0;
      res_d[3] = b1;
      cnt_d    = flush_pair ? 3'd4 : 3'd2;
    end else if (flush_pair) begin
      res_d[0] = b0;
      res_d[1] = b1;
      cnt_d    = 3'd2;
    end
  end

  pfe_pair u_pair_a (
    .first_i  (held_q),
    .second_i (a_second),
    .first_o  (a0),
    .second_o (a1)
  );

  pfe_pair u_pair_b (
    .first_i  (flush_letter),
    .second_i (PAD_LETTER),
    .first_o  (b0),
    .second_o (b1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      held_q       <= '0;
      held_valid_q <= 1'b0;
      cnt_q        <= '0;
      idx_q        <= '0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        in_valid_q <= 1'b1;
      end else if (move) begin
        in_valid_q <= 1'b0;
      end
      if (move) begin
        held_q       <= held_d;
        held_valid_q <= held_valid_d;
        cnt_q        <= cnt_d;
        idx_q        <= '0;
      end else if (out_fire) begin
        if (out_last) begin
          cnt_q <= '0;
        end else begin
          idx_q <= idx_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.in_byte;
      eom_q     <= in_i.end_of_message;
    end
    if (move) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire
